[hw/rtl/sau_pkg.sv]
package sau_pkg;

  // bus and pin events
  typedef enum logic [3:0] {
    EvWrCtrl  = 4'd0,
    EvWrData  = 4'd1,
    EvRdStat  = 4'd2,
    EvRdData  = 4'd3,
    EvRxd     = 4'd4,
    EvTxc     = 4'd5,
    EvRxc     = 4'd6,
    EvDsr     = 4'd7,
    EvCts     = 4'd8,
    EvSyndet  = 4'd9,
    EvByteIn  = 4'd10,
    EvByteOut = 4'd11,
    EvReset   = 4'd12
  } ev_e;

  // set-up sequence
  localparam logic [1:0] PhMode  = 2'd0;
  localparam logic [1:0] PhSync1 = 2'd1;
  localparam logic [1:0] PhSync2 = 2'd2;
  localparam logic [1:0] PhCmd   = 2'd3;

  // receiver phases
  localparam logic [2:0] RxNone  = 3'd0;
  localparam logic [2:0] RxHunt  = 3'd1;
  localparam logic [2:0] RxWait  = 3'd2;
  localparam logic [2:0] RxStart = 3'd3;
  localparam logic [2:0] RxData  = 3'd4;
  localparam logic [2:0] RxPar   = 3'd5;
  localparam logic [2:0] RxStop  = 3'd6;

  // transmitter phases
  localparam logic [2:0] TxNone   = 3'd0;
  localparam logic [2:0] TxStart  = 3'd1;
  localparam logic [2:0] TxData   = 3'd2;
  localparam logic [2:0] TxPar    = 3'd3;
  localparam logic [2:0] TxStop   = 3'd4;
  localparam logic [2:0] TxStop15 = 3'd5;
  localparam logic [2:0] TxStop2  = 3'd6;
  localparam logic [2:0] TxIdle   = 3'd7;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] value;
    logic       level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       txd;
    logic       txrdy;
    logic       txempty;
    logic       rxrdy;
    logic       dtr_n;
    logic       rts_n;
    logic       syn_brk;
  } res_t;

  typedef struct packed {
    logic [1:0] init_phase;
    logic [7:0] mode_word;
    logic [7:0] sync1;
    logic [7:0] sync2;
    logic [7:0] cmd;
    logic [3:0] char_length;
    logic [6:0] clock_factor;
    logic       sync_mode;
    logic       txr, rxr, txe, pe, oe, fe, syn;
    logic [2:0] rx_phase;
    logic [1:0] rx_tag;
    logic [2:0] tx_phase;
    logic [1:0] tx_tag;
    logic       rx_break, tx_break;
    logic [1:0] break_count;
    logic       p_rxd, p_rxc, p_txd, p_dsr, p_cts, p_txc;
    logic [7:0] tx_buffer, rx_buffer, tx_shifter, rx_shifter;
    logic       par_tx, par_rx;
    logic [3:0] tx_bit_count, rx_bit_count;
    logic [6:0] tx_fc, rx_fc;
  } state_t;

endpackage

[hw/rtl/sau_core.sv]
module sau_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  sau_pkg::item_t item_i,
  input  logic           bt_mode_i,
  output sau_pkg::res_t  res_o
);
  import sau_pkg::*;

  state_t st_q, st_d;

  function automatic logic par_of(state_t s, logic [7:0] v);
    logic p;
    p = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < s.char_length) p = p ^ v[i];
    end
    return s.mode_word[5] ? p : ~p;
  endfunction

  function automatic state_t prep_async_tx(state_t s);
    state_t r;
    r = s;
    if (!r.txr) begin
      r.tx_phase     = TxStart;
      r.tx_shifter   = r.tx_buffer;
      r.par_tx       = par_of(r, r.tx_buffer);
      r.tx_bit_count = r.char_length;
      r.txr          = 1'b1;
    end else begin
      r.txe      = 1'b1;
      r.tx_phase = TxIdle;
    end
    r.tx_fc = r.clock_factor;
    return r;
  endfunction

  function automatic state_t prep_sync_tx(state_t s);
    state_t r;
    r = s;
    if (r.tx_tag == 2'd1 && !r.mode_word[7]) begin
      r.tx_tag     = 2'd2;
      r.tx_shifter = r.sync2;
    end else if (!r.txr) begin
      r.tx_tag     = 2'd0;
      r.tx_shifter = r.tx_buffer;
      r.txr        = 1'b1;
    end else begin
      r.tx_tag     = 2'd1;
      r.tx_shifter = r.sync1;
      r.txe        = 1'b1;
    end
    r.tx_phase     = TxData;
    r.par_tx       = par_of(r, r.tx_shifter);
    r.tx_bit_count = r.char_length;
    return r;
  endfunction

  function automatic state_t prep_sync_rx(state_t s, logic hunt, logic second);
    state_t r;
    r = s;
    if (hunt) begin
      r.rx_phase = RxHunt;
      if (!r.mode_word[6]) begin
        r.rx_tag       = second ? 2'd2 : 2'd1;
        r.rx_shifter   = second ? r.sync2 : r.sync1;
        r.par_rx       = par_of(r, r.rx_shifter);
        r.rx_bit_count = r.char_length + 4'd1;
      end else begin
        r.rx_tag = 2'd0;
      end
      r.rxr = 1'b0;
    end else begin
      r.rx_phase     = RxData;
      r.rx_tag       = second ? 2'd2 : 2'd1;
      r.rx_bit_count = r.char_length;
      r.rx_shifter   = 8'd0;
    end
    return r;
  endfunction

  function automatic state_t sync_found(state_t s, logic in_hunt);
    state_t r;
    r = s;
    if (r.rx_tag == 2'd1 && !r.mode_word[7]) begin
      r = prep_sync_rx(r, in_hunt, 1'b1);
    end else begin
      r     = prep_sync_rx(r, 1'b0, 1'b0);
      r.syn = 1'b1;
    end
    return r;
  endfunction

  function automatic state_t char_rx(state_t s, logic [7:0] v);
    state_t r;
    r = s;
    r.rx_buffer = v;
    if (r.rxr) r.oe = 1'b1;
    r.rxr = 1'b1;
    return r;
  endfunction

  function automatic state_t sync_char_done(state_t s);
    state_t r;
    logic [7:0] v;
    r = s;
    v = r.rx_shifter;
    if ((r.rx_tag == 2'd1 && v == r.sync1) || (r.rx_tag == 2'd2 && v == r.sync2)) begin
      r = sync_found(r, 1'b0);
    end else begin
      r.rx_phase     = RxData;
      r.rx_bit_count = r.char_length;
      r.rx_shifter   = 8'd0;
    end
    return char_rx(r, v);
  endfunction

  // transmit clock edge, bits change on the falling edge
  function automatic state_t tx_edge(state_t s, logic lvl);
    state_t r;
    logic   old;
    r = s;
    old = r.p_txc;
    r.p_txc = lvl;
    if (r.init_phase == PhCmd && !r.tx_break && old != lvl && !lvl) begin
      if (r.sync_mode) begin
        if (r.tx_phase == TxData) begin
          if (!((r.p_cts || !r.cmd[0]) && r.tx_bit_count == r.char_length)) begin
            r.p_txd      = r.tx_shifter[0];
            r.tx_shifter = r.tx_shifter >> 1;
            if (r.tx_bit_count != 4'd0) r.tx_bit_count = r.tx_bit_count - 4'd1;
            if (r.tx_bit_count == 4'd0) begin
              if (r.mode_word[4]) r.tx_phase = TxPar;
              else r = prep_sync_tx(r);
            end
          end
        end else if (r.tx_phase == TxPar) begin
          r.p_txd = r.par_tx;
          r = prep_sync_tx(r);
        end
      end else if (r.tx_fc > 7'd1) begin
        r.tx_fc = r.tx_fc - 7'd1;
      end else begin
        r.tx_fc = r.clock_factor;
        case (r.tx_phase)
          TxStart: begin
            if (!(r.p_cts || !r.cmd[0])) begin
              r.p_txd    = 1'b0;
              r.tx_phase = TxData;
            end
          end
          TxData: begin
            r.p_txd      = r.tx_shifter[0];
            r.tx_shifter = r.tx_shifter >> 1;
            if (r.tx_bit_count != 4'd0) r.tx_bit_count = r.tx_bit_count - 4'd1;
            if (r.tx_bit_count == 4'd0) r.tx_phase = r.mode_word[4] ? TxPar : TxStop;
          end
          TxPar: begin
            r.p_txd    = r.par_tx;
            r.tx_phase = TxStop;
          end
          TxStop: begin
            r.p_txd = 1'b1;
            case (r.mode_word[7:6])
              2'd2:    r.tx_phase = TxStop15;
              2'd3:    r.tx_phase = TxStop2;
              default: r.tx_phase = TxIdle;
            endcase
          end
          TxStop15: begin
            if (r.tx_fc > 7'd1) r.tx_fc = r.tx_fc >> 1;
            r.p_txd    = 1'b1;
            r.tx_phase = TxIdle;
          end
          TxStop2: begin
            r.p_txd    = 1'b1;
            r.tx_phase = TxIdle;
          end
          TxIdle: begin
            r = prep_async_tx(r);
            if (r.tx_phase == TxStart) begin
              r.p_txd    = 1'b0;
              r.tx_phase = TxData;
            end
          end
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  // receive clock edge, bits sampled on the rising edge
  function automatic state_t rx_edge(state_t s, logic lvl);
    state_t r;
    logic   old;
    logic   go;
    r = s;
    old = r.p_rxc;
    r.p_rxc = lvl;
    go = (r.init_phase == PhCmd) && (old != lvl) && lvl;
    if (go && !r.sync_mode) begin
      if (r.rx_fc > 7'd1) begin
        r.rx_fc = r.rx_fc - 7'd1;
        go = 1'b0;
      end else begin
        r.rx_fc = r.clock_factor;
      end
    end
    if (go) begin
      case (r.rx_phase)
        RxHunt: begin
          if (!r.mode_word[6]) begin
            if (r.rx_bit_count > 4'd1) begin
              r.rx_bit_count = r.rx_bit_count - 4'd1;
              if (r.rx_shifter[0] == r.p_rxd) r.rx_shifter = r.rx_shifter >> 1;
              else r = prep_sync_rx(r, 1'b1, 1'b0);
            end else begin
              r.rx_bit_count = 4'd0;
              if (r.par_rx == r.p_rxd) r = sync_found(r, 1'b1);
              else r = prep_sync_rx(r, 1'b1, 1'b0);
            end
          end
        end
        RxWait: begin
          if (!r.p_rxd && r.break_count != 2'd0) begin
            r.rx_phase = RxStart;
            r.rx_fc = (r.clock_factor > 7'd1) ? (r.clock_factor >> 1) : r.clock_factor;
          end
        end
        RxStart: begin
          if (r.p_rxd) begin
            r.rx_phase = RxWait;
          end else begin
            r.rx_phase     = RxData;
            r.rx_shifter   = 8'd0;
            r.rx_bit_count = r.char_length;
          end
        end
        RxData: begin
          r.rx_shifter = {r.p_rxd, r.rx_shifter[7:1]};
          if (r.rx_bit_count != 4'd0) r.rx_bit_count = r.rx_bit_count - 4'd1;
          if (r.rx_bit_count == 4'd0) begin
            r.rx_shifter = r.rx_shifter >> (4'd8 - r.char_length);
            if (r.mode_word[4]) begin
              r.rx_phase = RxPar;
              r.par_rx   = par_of(r, r.rx_shifter);
            end else if (r.sync_mode) begin
              r = sync_char_done(r);
            end else begin
              r.rx_phase = RxStop;
            end
          end
        end
        RxPar: begin
          if (r.p_rxd != r.par_rx) r.pe = 1'b1;
          if (r.sync_mode) r = sync_char_done(r);
          else r.rx_phase = RxStop;
        end
        RxStop: begin
          if (!r.p_rxd) begin
            r.fe = 1'b1;
            r.break_count = r.break_count + 2'd1;
            if (r.break_count > 2'd1) begin
              r.break_count = 2'd2;
              r.rx_break    = 1'b1;
            end
          end
          r = char_rx(r, r.rx_shifter);
          r.rx_phase = RxWait;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic state_t write_mode(state_t s, logic [7:0] v);
    state_t r;
    r = s;
    r.mode_word    = v;
    r.char_length  = {2'b00, v[3:2]} + 4'd5;
    r.rx_bit_count = r.char_length;
    r.tx_bit_count = r.char_length;
    case (v[1:0])
      2'd1:    r.clock_factor = 7'd1;
      2'd2:    r.clock_factor = 7'd16;
      2'd3:    r.clock_factor = 7'd64;
      default: r.clock_factor = 7'd0;
    endcase
    r.sync_mode = (v[1:0] == 2'd0);
    r.syn = 1'b0;
    r.txe = 1'b1;
    r.txr = 1'b1;
    r.rxr = 1'b0;
    r.pe = 1'b0; r.oe = 1'b0; r.fe = 1'b0;
    r.rx_phase = RxNone;
    r.rx_tag = 2'd0;
    r.rx_break = 1'b0;
    r.break_count = 2'd0;
    r.tx_phase = TxNone;
    r.tx_tag = 2'd0;
    r.tx_break = 1'b0;
    r.p_rxd = 1'b1; r.p_rxc = 1'b1; r.p_txd = 1'b1; r.p_dsr = 1'b1; r.p_cts = 1'b1;
    r.p_txc = 1'b0;
    if (r.sync_mode) begin
      r.init_phase = PhSync1;
    end else begin
      r.init_phase = PhCmd;
      r = prep_async_tx(r);
      r.rx_phase = RxWait;
    end
    return r;
  endfunction

  function automatic state_t write_command(state_t s, logic [7:0] v);
    state_t r;
    r = s;
    r.cmd = v;
    if (v[6]) begin
      r.init_phase = PhMode;
    end else begin
      if (v[4]) begin
        r.pe = 1'b0; r.oe = 1'b0; r.fe = 1'b0;
      end
      if (v[3]) begin
        r.tx_break = 1'b1;
        r.p_txd    = 1'b0;
      end else if (r.tx_break) begin
        r.tx_break = 1'b0;
        r.p_txd    = 1'b1;
        if (r.sync_mode) r = prep_sync_tx(r);
        else r = prep_async_tx(r);
      end
      if (r.sync_mode && v[7]) begin
        r.rx_phase = RxHunt;
        r.rx_tag   = r.mode_word[6] ? 2'd0 : 2'd1;
      end
    end
    return r;
  endfunction

  function automatic state_t write_ctrl(state_t s, logic [7:0] v);
    state_t r;
    r = s;
    unique case (r.init_phase)
      PhMode: r = write_mode(r, v);
      PhSync1: begin
        r.sync1 = v;
        if (!r.mode_word[7]) begin
          r.init_phase = PhSync2;
        end else begin
          r.init_phase = PhCmd;
          r = prep_sync_tx(r);
          r = prep_sync_rx(r, 1'b1, 1'b0);
        end
      end
      PhSync2: begin
        r.sync2 = v;
        r.init_phase = PhCmd;
        r = prep_sync_tx(r);
        r = prep_sync_rx(r, 1'b1, 1'b0);
      end
      default: r = write_command(r, v);
    endcase
    return r;
  endfunction

  // state after reset
  function automatic state_t reset_state();
    state_t r;
    r = '0;
    r.char_length = 4'd5;
    r.txr   = 1'b1;
    r.txe   = 1'b1;
    r.p_rxd = 1'b1;
    r.p_rxc = 1'b1;
    r.p_txd = 1'b1;
    r.p_dsr = 1'b1;
    r.p_cts = 1'b1;
    return r;
  endfunction

  // one event: next state and result word
  always_comb begin
    state_t s;
    logic [7:0] rd;
    s  = st_q;
    rd = 8'hFF;
    unique case (item_i.mode)
      EvWrCtrl: s = write_ctrl(s, item_i.value);
      EvWrData: begin
        if (s.init_phase == PhCmd) begin
          s.tx_buffer = item_i.value;
          s.txe = 1'b0;
          s.txr = 1'b0;
        end
      end
      EvRdStat: begin
        rd = {~s.p_dsr, s.syn, s.fe, s.oe, s.pe, s.txe, s.rxr, s.txr};
        if (s.sync_mode && !s.mode_word[6]) s.syn = 1'b0;
      end
      EvRdData: begin
        if (s.rxr) begin
          rd = s.rx_buffer;
          s.rxr = 1'b0;
        end
      end
      EvRxd: begin
        if (!s.sync_mode && s.rx_phase == RxWait && s.p_rxd && !item_i.level) begin
          s.rx_phase = RxStart;
          s.rx_fc = (s.clock_factor > 7'd1) ? (s.clock_factor >> 1) : s.clock_factor;
        end
        if (!s.sync_mode && item_i.level) begin
          s.rx_break = 1'b0;
          s.break_count = 2'd0;
        end
        s.p_rxd = item_i.level;
      end
      EvTxc: s = tx_edge(s, item_i.level);
      EvRxc: s = rx_edge(s, item_i.level);
      EvDsr: s.p_dsr = item_i.level;
      EvCts: s.p_cts = item_i.level;
      EvSyndet: begin
        if (s.sync_mode && s.mode_word[6] && s.syn != item_i.level) begin
          s.syn = item_i.level;
          if (item_i.level) s = prep_sync_rx(s, 1'b0, 1'b0);
        end
      end
      EvByteIn: begin
        s.rx_shifter = item_i.value;
        s = char_rx(s, item_i.value);
      end
      EvByteOut: begin
        if (!s.txr) begin
          if (bt_mode_i) begin
            s.txr = 1'b1;
            if (s.sync_mode) s = prep_sync_tx(s);
            else s = prep_async_tx(s);
          end
          rd = s.tx_buffer;
        end else begin
          rd = 8'd0;
        end
      end
      EvReset: s.init_phase = PhMode;
      default: ;
    endcase
    st_d = s;
    res_o.read_data = rd;
    res_o.txd       = s.p_txd;
    res_o.txrdy     = s.txr && s.cmd[0] && !s.p_cts;
    res_o.txempty   = s.txe;
    res_o.rxrdy     = s.rxr;
    res_o.dtr_n     = ~s.cmd[1];
    res_o.rts_n     = ~s.cmd[5];
    res_o.syn_brk   = s.sync_mode ? (!s.mode_word[6] && s.syn) : s.rx_break;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= reset_state();
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

endmodule

[hw/rtl/sync_async_usart.sv]
// Serial controller, one event word in, one result word out.
// Input channel: in_valid_i/in_ready_o with in_data_i (event code, byte,
// pin level). Output channel: out_valid_o/out_ready_i with out_data_o
// (read byte, 0xFF or 0x00, line levels and status pins after the event).
// cfg_we_i writes cfg_data_i into the byte transfer mode bit at once.
// Each result word is registered and appears the cycle after its event.
// Throughput: one event per cycle; the state update is a single pass of
// logic between the event handshake and the result register.
// While a result waits, a new event is still taken if out_ready_i is high
// in that cycle; with out_ready_i low and a result pending, in_ready_o
// drops and the pending result holds.
// Reset clears the result register and puts the controller back to
// expecting a mode word, with the transmitter reported empty and ready.
module sync_async_usart (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sau_pkg::item_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sau_pkg::res_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_data_i
);
  import sau_pkg::*;

  logic  accept;
  logic  bt_mode_q;
  logic  out_valid_q;
  res_t  res;
  res_t  out_q;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // config bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bt_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      bt_mode_q <= cfg_data_i;
    end
  end

  sau_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_data_i),
    .bt_mode_i (bt_mode_q),
    .res_o     (res)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (accept) begin
      out_q <= res;
    end
  end

endmodule

[hw/rtl/sau_checker.sv]
module sau_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input sau_pkg::res_t out_data_o
);

  // every taken word yields a result next cycle
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after taken word");

  // free output side never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with output free");

  // pending result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("pending result changed");

  // no result appears without a taken word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result without word");

endmodule

bind sync_async_usart sau_checker u_sau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
